### sv/look_at_view_matrix_defines.svh
// assertion macros for the look-at view matrix block
// used by the top level; expects aclk and aresetn in the including scope
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LAVM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("look_at_view_matrix: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define LAVM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("look_at_view_matrix: next-cycle check failed");

`endif

### sv/lavm_pkg.sv
// shared types and pipeline latencies for the look-at view matrix block
// no dependencies
package lavm_pkg;

    // three 32-bit words, element 0 in the low bits
    typedef logic [2:0][31:0] vec32x3_t;
    // three 64-bit words, element 0 in the low bits
    typedef logic [2:0][63:0] vec64x3_t;

    // result transfer layout, side_x in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [32:0] forward_shift;
        logic [32:0] upward_shift;
        logic [32:0] side_shift;
        vec32x3_t    forward;
        vec32x3_t    upward;
        vec32x3_t    side;
    } result_t;

    localparam int IN_W  = 288;
    localparam int OUT_W = $bits(result_t);

    // stage counts of the sub-pipelines
    localparam int NORM_LAT   = 72;
    localparam int CROSS_LAT  = 2;
    localparam int ROUND_LAT  = 1;
    localparam int XLATE_LAT  = 4;

endpackage

### sv/lavm_delay.sv
// enabled shift line that delays a payload by a fixed number of stages
// no package dependencies
module lavm_delay #(
    parameter int W = 96,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dly_reg [0:D-1];

    // shift one place per enabled cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= din;
            for (int k = 1; k < D; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign dout = dly_reg[D-1];

endmodule

### sv/lavm_cross.sv
// pipelined cross product of two signed 32-bit three-vectors
// depends on lavm_pkg
module lavm_cross (
    input  logic               aclk,
    input  logic               en,
    input  lavm_pkg::vec32x3_t a_in,
    input  lavm_pkg::vec32x3_t b_in,
    output lavm_pkg::vec64x3_t c_out
);
    import lavm_pkg::*;

    logic [5:0][63:0] prod_reg;
    vec64x3_t         c_reg;

    // six partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= 64'($signed(a_in[1]) * $signed(b_in[2]));
            prod_reg[1] <= 64'($signed(a_in[2]) * $signed(b_in[1]));
            prod_reg[2] <= 64'($signed(a_in[2]) * $signed(b_in[0]));
            prod_reg[3] <= 64'($signed(a_in[0]) * $signed(b_in[2]));
            prod_reg[4] <= 64'($signed(a_in[0]) * $signed(b_in[1]));
            prod_reg[5] <= 64'($signed(a_in[1]) * $signed(b_in[0]));
        end
    end

    // differences
    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[0] <= prod_reg[0] - prod_reg[1];
            c_reg[1] <= prod_reg[2] - prod_reg[3];
            c_reg[2] <= prod_reg[4] - prod_reg[5];
        end
    end

    assign c_out = c_reg;

endmodule

### sv/lavm_norm3.sv
// pipelined normalization of a signed three-vector to Q1.30
// depends on lavm_pkg; one bit per stage for square root and division
module lavm_norm3 (
    input  logic               aclk,
    input  logic               en,
    input  lavm_pkg::vec64x3_t v_in,
    output lavm_pkg::vec32x3_t o_out
);
    import lavm_pkg::*;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;

    function automatic logic [2:0] msb8(input logic [7:0] b);
        logic [2:0] r;
        r = '0;
        for (int j = 0; j < 8; j++) begin
            if (b[j]) r = 3'(j);
        end
        return r;
    endfunction

    // magnitude stage
    logic [2:0][63:0] mag1_reg;
    logic [2:0]       neg1_reg;
    // byte group stage
    logic [7:0]       nz2_reg;
    logic [7:0][2:0]  loc2_reg;
    logic [2:0][63:0] mag2_reg;
    logic [2:0]       neg2_reg;
    // leading one stage
    logic [5:0]       p3_reg;
    logic             zero3_reg;
    logic [2:0][63:0] mag3_reg;
    logic [2:0]       neg3_reg;
    // scaled components and later stages
    logic [2:0][29:0] m4_reg, m5_reg, m6_reg;
    logic             zero4_reg, zero5_reg, zero6_reg;
    logic [2:0]       neg4_reg, neg5_reg, neg6_reg;
    logic [2:0][59:0] sq5_reg;
    logic [60:0]      s6_reg;
    logic [59:0]      sq6_reg;

    // square root stages
    logic [63:0]      rem_reg [0:SQ_STEPS];
    logic [63:0]      res_reg [0:SQ_STEPS];
    logic [2:0][29:0] mq_reg  [0:SQ_STEPS];
    logic             zq_reg  [0:SQ_STEPS];
    logic [2:0]       nq_reg  [0:SQ_STEPS];
    logic [63:0]      rem_next [0:SQ_STEPS-1];
    logic [63:0]      res_next [0:SQ_STEPS-1];

    // division stages
    logic [2:0][61:0] rm_reg  [0:DIV_STEPS];
    logic [2:0][30:0] q_reg   [0:DIV_STEPS];
    logic [30:0]      den_reg [0:DIV_STEPS];
    logic             zd_reg  [0:DIV_STEPS];
    logic [2:0]       nd_reg  [0:DIV_STEPS];
    logic [2:0][61:0] rm_next [0:DIV_STEPS-1];
    logic [2:0][30:0] q_next  [0:DIV_STEPS-1];

    vec32x3_t o_reg;

    // magnitudes and signs
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i] <= v_in[i][63] ? (~v_in[i] + 64'd1) : v_in[i];
                neg1_reg[i] <= v_in[i][63];
            end
        end
    end

    // highest bit per byte of the or of all magnitudes
    always_ff @(posedge aclk) begin
        logic [63:0] orv;
        orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        if (en) begin
            for (int g = 0; g < 8; g++) begin
                nz2_reg[g]  <= |orv[8*g +: 8];
                loc2_reg[g] <= msb8(orv[8*g +: 8]);
            end
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // position of the leading one
    always_ff @(posedge aclk) begin
        logic [5:0] p;
        p = '0;
        for (int g = 0; g < 8; g++) begin
            if (nz2_reg[g]) p = {3'(g), loc2_reg[g]};
        end
        if (en) begin
            p3_reg    <= p;
            zero3_reg <= ~|nz2_reg;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    // scale so the largest magnitude sits in bits 29 down
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (p3_reg > 6'd29) begin
                    m4_reg[i] <= 30'(mag3_reg[i] >> (p3_reg - 6'd29));
                end else begin
                    m4_reg[i] <= 30'(mag3_reg[i] << (6'd29 - p3_reg));
                end
            end
            zero4_reg <= zero3_reg;
            neg4_reg  <= neg3_reg;
        end
    end

    // squares
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= 60'(m4_reg[i] * m4_reg[i]);
            end
            m5_reg    <= m4_reg;
            zero5_reg <= zero4_reg;
            neg5_reg  <= neg4_reg;
        end
    end

    // partial sum
    always_ff @(posedge aclk) begin
        if (en) begin
            s6_reg    <= {1'b0, sq5_reg[0]} + {1'b0, sq5_reg[1]};
            sq6_reg   <= sq5_reg[2];
            m6_reg    <= m5_reg;
            zero6_reg <= zero5_reg;
            neg6_reg  <= neg5_reg;
        end
    end

    // square root step, one result bit each
    always_comb begin
        logic [63:0] rbit;
        logic [63:0] t;
        for (int k = 0; k < SQ_STEPS; k++) begin
            rbit = 64'd1 << (62 - 2 * k);
            t    = res_reg[k] + rbit;
            if (rem_reg[k] >= t) begin
                rem_next[k] = rem_reg[k] - t;
                res_next[k] = (res_reg[k] >> 1) + rbit;
            end else begin
                rem_next[k] = rem_reg[k];
                res_next[k] = res_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {3'b0, s6_reg} + {4'b0, sq6_reg};
            res_reg[0] <= '0;
            mq_reg[0]  <= m6_reg;
            zq_reg[0]  <= zero6_reg;
            nq_reg[0]  <= neg6_reg;
            for (int k = 0; k < SQ_STEPS; k++) begin
                rem_reg[k+1] <= rem_next[k];
                res_reg[k+1] <= res_next[k];
                mq_reg[k+1]  <= mq_reg[k];
                zq_reg[k+1]  <= zq_reg[k];
                nq_reg[k+1]  <= nq_reg[k];
            end
        end
    end

    // restoring division step, one quotient bit each
    always_comb begin
        logic [61:0] dsh;
        for (int k = 0; k < DIV_STEPS; k++) begin
            dsh = {31'b0, den_reg[k]} << (30 - k);
            for (int i = 0; i < 3; i++) begin
                if (rm_reg[k][i] >= dsh) begin
                    rm_next[k][i] = rm_reg[k][i] - dsh;
                    q_next[k][i]  = q_reg[k][i] | (31'd1 << (30 - k));
                end else begin
                    rm_next[k][i] = rm_reg[k][i];
                    q_next[k][i]  = q_reg[k][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // rounded numerator: scaled component times 2^30 plus half the norm
            for (int i = 0; i < 3; i++) begin
                rm_reg[0][i] <= {2'b0, mq_reg[SQ_STEPS][i], 30'b0}
                              + {32'b0, res_reg[SQ_STEPS][30:1]};
            end
            q_reg[0]   <= '0;
            den_reg[0] <= res_reg[SQ_STEPS][30:0];
            zd_reg[0]  <= zq_reg[SQ_STEPS];
            nd_reg[0]  <= nq_reg[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++) begin
                rm_reg[k+1]  <= rm_next[k];
                q_reg[k+1]   <= q_next[k];
                den_reg[k+1] <= den_reg[k];
                zd_reg[k+1]  <= zd_reg[k];
                nd_reg[k+1]  <= nd_reg[k];
            end
        end
    end

    // sign and zero-length handling
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (zd_reg[DIV_STEPS]) begin
                    o_reg[i] <= '0;
                end else if (nd_reg[DIV_STEPS][i]) begin
                    o_reg[i] <= ~{1'b0, q_reg[DIV_STEPS][i]} + 32'd1;
                end else begin
                    o_reg[i] <= {1'b0, q_reg[DIV_STEPS][i]};
                end
            end
        end
    end

    assign o_out = o_reg;

endmodule

### sv/lavm_xlate.sv
// pipelined negated dot product of an axis with the eye, rounded to Q17.16
// depends on lavm_pkg
module lavm_xlate (
    input  logic               aclk,
    input  logic               en,
    input  lavm_pkg::vec32x3_t axis_in,
    input  lavm_pkg::vec32x3_t eye_in,
    output logic [32:0]        shift_out
);
    import lavm_pkg::*;

    logic [2:0][63:0] p_reg;
    logic [63:0]      s01_reg;
    logic [63:0]      p2_reg;
    logic [63:0]      sum_reg;
    logic [32:0]      shift_reg;

    // products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= 64'($signed(axis_in[i]) * $signed(eye_in[i]));
            end
        end
    end

    // two adds over two stages
    always_ff @(posedge aclk) begin
        if (en) begin
            s01_reg <= p_reg[0] + p_reg[1];
            p2_reg  <= p_reg[2];
            sum_reg <= s01_reg + p2_reg;
        end
    end

    // negate, round half away from zero, saturate
    always_ff @(posedge aclk) begin
        logic [63:0] mag;
        logic [33:0] q;
        logic        pos;
        pos = ~sum_reg[63] & (|sum_reg);
        mag = sum_reg[63] ? (~sum_reg + 64'd1) : sum_reg;
        q   = 34'((mag + 64'd536870912) >> 30);
        if (en) begin
            if (pos) begin
                if (q > 34'h1_0000_0000) begin
                    shift_reg <= 33'h1_0000_0000;
                end else begin
                    shift_reg <= 33'(~q + 34'd1);
                end
            end else begin
                if (q > 34'h0_FFFF_FFFF) begin
                    shift_reg <= 33'h0_FFFF_FFFF;
                end else begin
                    shift_reg <= 33'(q);
                end
            end
        end
    end

    assign shift_out = shift_reg;

endmodule

### sv/look_at_view_matrix.sv
// channel   | dir | ports                     | content
// s_ camera | in  | s_tvalid s_tready s_tdata | eye, target, up in Q16.16
// m_ view   | out | m_tvalid m_tready m_tdata | side, upward, forward axes, translations
//
// one camera setup per cycle while the skid register is empty, pipelined up to m_tvalid
// (each normalize unit: scale stages, 32 square root stages, then division stages)
// synchronous active-low reset clears the valid line and the output and skid valid flags
// a stalled output parks one result in a skid register; input stalls once it fills
//
// top level of the look-at view matrix block
// depends on lavm_pkg, lavm_delay, lavm_cross, lavm_norm3, lavm_xlate and the defines header
`include "look_at_view_matrix_defines.svh"

module look_at_view_matrix (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [lavm_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // side_x, side_y, side_z, upward_x, upward_y, upward_z, forward_x, forward_y,
    // forward_z, side_shift, upward_shift, forward_shift, zero pad
    output logic [lavm_pkg::OUT_W-1:0]  m_tdata
);
    import lavm_pkg::*;

    localparam int LAT_F   = 1 + NORM_LAT;
    localparam int LAT_S   = LAT_F + CROSS_LAT + NORM_LAT;
    localparam int LAT_W   = LAT_S + CROSS_LAT + ROUND_LAT;
    localparam int LAT_OUT = LAT_W + XLATE_LAT;

    function automatic logic [31:0] round_q30_clamp(input logic [63:0] c);
        logic [63:0] mag;
        logic [34:0] q;
        logic [31:0] qc;
        mag = c[63] ? (~c + 64'd1) : c;
        q   = 35'((mag + 64'd536870912) >> 30);
        qc  = (q > 35'd1073741824) ? 32'd1073741824 : q[31:0];
        return c[63] ? (~qc + 32'd1) : qc;
    endfunction

    logic               en;
    logic [LAT_OUT-1:0] vld_reg;
    vec32x3_t           eye, target, up;
    vec64x3_t           d_reg;
    vec32x3_t           up_f, fwd, fwd_s, fwd_w, fwd_o;
    vec64x3_t           side_c, up_c;
    vec32x3_t           side, side_w, side_o;
    vec32x3_t           upw_reg, upw_o;
    vec32x3_t           eye_w;
    logic [32:0]        side_sh, upw_sh, fwd_sh;
    result_t            pipe_res;
    logic               pipe_take;
    logic               out_vld_reg, skid_vld_reg;
    result_t            out_reg, skid_reg;

    assign en       = ~skid_vld_reg;
    assign s_tready = en;

    assign eye    = s_tdata[95:0];
    assign target = s_tdata[191:96];
    assign up     = s_tdata[287:192];

    // valid line that runs beside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT_OUT-2:0], s_tvalid};
        end
    end

    // eye minus target
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= {{32{eye[i][31]}}, eye[i]} - {{32{target[i][31]}}, target[i]};
            end
        end
    end

    // forward axis
    lavm_norm3 u_norm_fwd (.aclk(aclk), .en(en), .v_in(d_reg), .o_out(fwd));

    lavm_delay #(.W(96), .D(LAT_F)) u_dly_up (
        .aclk(aclk), .en(en), .din(up), .dout(up_f));

    // side axis from up cross forward
    lavm_cross u_cross_side (.aclk(aclk), .en(en), .a_in(up_f), .b_in(fwd), .c_out(side_c));
    lavm_norm3 u_norm_side (.aclk(aclk), .en(en), .v_in(side_c), .o_out(side));

    lavm_delay #(.W(96), .D(CROSS_LAT + NORM_LAT)) u_dly_fwd_s (
        .aclk(aclk), .en(en), .din(fwd), .dout(fwd_s));

    // upward axis from forward cross side
    lavm_cross u_cross_up (.aclk(aclk), .en(en), .a_in(fwd_s), .b_in(side), .c_out(up_c));

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                upw_reg[i] <= round_q30_clamp(up_c[i]);
            end
        end
    end

    lavm_delay #(.W(96), .D(CROSS_LAT + ROUND_LAT)) u_dly_side_w (
        .aclk(aclk), .en(en), .din(side), .dout(side_w));
    lavm_delay #(.W(96), .D(CROSS_LAT + ROUND_LAT)) u_dly_fwd_w (
        .aclk(aclk), .en(en), .din(fwd_s), .dout(fwd_w));
    lavm_delay #(.W(96), .D(LAT_W)) u_dly_eye (
        .aclk(aclk), .en(en), .din(eye), .dout(eye_w));

    // translations
    lavm_xlate u_xlate_side (.aclk(aclk), .en(en), .axis_in(side_w), .eye_in(eye_w),
                             .shift_out(side_sh));
    lavm_xlate u_xlate_up   (.aclk(aclk), .en(en), .axis_in(upw_reg), .eye_in(eye_w),
                             .shift_out(upw_sh));
    lavm_xlate u_xlate_fwd  (.aclk(aclk), .en(en), .axis_in(fwd_w), .eye_in(eye_w),
                             .shift_out(fwd_sh));

    lavm_delay #(.W(96), .D(XLATE_LAT)) u_dly_side_o (
        .aclk(aclk), .en(en), .din(side_w), .dout(side_o));
    lavm_delay #(.W(96), .D(XLATE_LAT)) u_dly_up_o (
        .aclk(aclk), .en(en), .din(upw_reg), .dout(upw_o));
    lavm_delay #(.W(96), .D(XLATE_LAT)) u_dly_fwd_o (
        .aclk(aclk), .en(en), .din(fwd_w), .dout(fwd_o));

    // assemble the finished result
    always_comb begin
        pipe_res               = '0;
        pipe_res.side          = side_o;
        pipe_res.upward        = upw_o;
        pipe_res.forward       = fwd_o;
        pipe_res.side_shift    = side_sh;
        pipe_res.upward_shift  = upw_sh;
        pipe_res.forward_shift = fwd_sh;
    end

    assign pipe_take = en & vld_reg[LAT_OUT-1];

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= pipe_take;
            end
        end else if (pipe_take) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_reg <= skid_vld_reg ? skid_reg : pipe_res;
        end else if (pipe_take) begin
            skid_reg <= pipe_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // checks
    `LAVM_ASSERT_NOW(a_skid_needs_out, skid_vld_reg, out_vld_reg)
    `LAVM_ASSERT_NEXT(a_stall_fills_skid, out_vld_reg && !m_tready && pipe_take, skid_vld_reg)
    `LAVM_ASSERT_NEXT(a_skid_drains, skid_vld_reg && m_tready, !skid_vld_reg && out_vld_reg)
    `LAVM_ASSERT_NOW(a_fwd_unit_range, out_vld_reg,
        $signed(out_reg.forward[0]) <= 32'sd1073741824 &&
        $signed(out_reg.forward[0]) >= -32'sd1073741824)

endmodule
